### hw/rtl/ldabk_pkg.sv
// Shared types and constants for the list deduplication block.
// Depends on nothing; every other file of the block uses it.
package ldabk_pkg;

    localparam int NODE_SLOTS_DEF = 131072;
    localparam int KEY_MAG_DEF    = 16384;

    localparam int ADDR_W  = 17;
    localparam int KEY_W   = 15;
    localparam int LINK_W  = 18;
    // Width of the walk tag kept in each seen-map entry.
    localparam int EPOCH_W = 8;

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_ADV   = 2'd2;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_NODE_RD,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic signed [KEY_W-1:0]  key;
        logic signed [LINK_W-1:0] link;
    } t_node;

endpackage

### hw/rtl/ldabk_if.sv
// Valid/ready channel interfaces for the input items and the result items.
// Depends on ldabk_pkg for the field widths.
interface ldabk_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [1:0]                           kind;
    logic [ldabk_pkg::ADDR_W-1:0]         node_addr;
    logic signed [ldabk_pkg::KEY_W-1:0]   node_key;
    logic signed [ldabk_pkg::LINK_W-1:0]  link_addr;
    logic signed [ldabk_pkg::LINK_W-1:0]  head_addr;

    modport source (output valid, kind, node_addr, node_key, link_addr, head_addr,
                    input ready);
    modport sink   (input valid, kind, node_addr, node_key, link_addr, head_addr,
                    output ready);
endinterface

interface ldabk_out_if;
    logic                                valid;
    logic                                ready;
    logic [ldabk_pkg::ADDR_W-1:0]        out_addr;
    logic signed [ldabk_pkg::KEY_W-1:0]  out_key;
    logic                                removed;
    logic                                walk_done;

    modport source (output valid, out_addr, out_key, removed, walk_done, input ready);
    modport sink   (input valid, out_addr, out_key, removed, walk_done, output ready);
endinterface

### hw/rtl/ldabk_node_mem.sv
// Node store: one write port for loads, one registered read port for the walk.
// Depends on ldabk_pkg for the node entry type.
module ldabk_node_mem #(
    parameter int NODE_SLOTS = ldabk_pkg::NODE_SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_wr_en,
    input  logic [$clog2(NODE_SLOTS)-1:0] i_wr_addr,
    input  ldabk_pkg::t_node              i_wr_data,
    input  logic                          i_rd_en,
    input  logic [$clog2(NODE_SLOTS)-1:0] i_rd_addr,
    output ldabk_pkg::t_node              o_rd_data
);

    ldabk_pkg::t_node r_mem [NODE_SLOTS];
    ldabk_pkg::t_node r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hw/rtl/ldabk_seen_mem.sv
// Seen-magnitude map: each entry holds the tag of the walk that last saw it.
// Depends on ldabk_pkg for the tag width.
module ldabk_seen_mem #(
    parameter int KEY_MAGNITUDES = ldabk_pkg::KEY_MAG_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_wr_en,
    input  logic [$clog2(KEY_MAGNITUDES)-1:0] i_wr_addr,
    input  logic [ldabk_pkg::EPOCH_W-1:0]     i_wr_data,
    input  logic                              i_rd_en,
    input  logic [$clog2(KEY_MAGNITUDES)-1:0] i_rd_addr,
    output logic [ldabk_pkg::EPOCH_W-1:0]     o_rd_data
);

    logic [ldabk_pkg::EPOCH_W-1:0] r_mem [KEY_MAGNITUDES];
    logic [ldabk_pkg::EPOCH_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hw/rtl/list_dedup_by_abs_key.sv
// Top level of the list deduplication block: walk sequencer and result register.
// Depends on ldabk_pkg, ldabk_if, ldabk_node_mem and ldabk_seen_mem.
//
//  Channel  Dir  Carries                                       Accepted when
//  i_in     in   kind, node_addr, node_key, link_addr,         valid && ready
//                head_addr
//  o_out    out  out_addr, out_key, removed, walk_done         valid && ready
//
// A load item finishes as it is taken, and so does a start unless the walk tag
// wraps. An advance over a node chains a node store read, then a seen-map read,
// then a seen-map write and result; at the end of the list it goes straight to
// the result. Reset starts a clearing pass over every seen-map entry; the
// same pass runs again on every 255th start, when the walk tag wraps.
// A waiting result does not block loads or starts; an advance waits in its
// last cycle until the result register is free.
module list_dedup_by_abs_key #(
    parameter int NODE_SLOTS     = ldabk_pkg::NODE_SLOTS_DEF,
    parameter int KEY_MAGNITUDES = ldabk_pkg::KEY_MAG_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ldabk_in_if.sink    i_in,
    ldabk_out_if.source o_out
);

    localparam int AW = $clog2(NODE_SLOTS);
    localparam int MW = $clog2(KEY_MAGNITUDES);
    localparam int EW = ldabk_pkg::EPOCH_W;

    ldabk_pkg::t_state r_state, n_state;

    logic signed [ldabk_pkg::LINK_W-1:0] r_cursor;
    logic [EW-1:0]                       r_epoch;
    logic [MW-1:0]                       r_clr;
    logic                                r_null;
    logic [ldabk_pkg::ADDR_W-1:0]        r_addr;
    logic [MW-1:0]                       r_mag;

    logic                                r_ovalid;
    logic [ldabk_pkg::ADDR_W-1:0]        r_out_addr;
    logic signed [ldabk_pkg::KEY_W-1:0]  r_out_key;
    logic                                r_out_removed;
    logic                                r_out_done;

    logic             accept;
    logic             in_ready;
    logic             node_we;
    logic             node_re;
    logic             seen_re;
    logic             seen_we;
    logic [MW-1:0]    seen_wa;
    logic [EW-1:0]    seen_wd;
    logic             out_free;
    logic             out_load;
    logic             clr_last;
    logic             cur_ok;
    logic             load_ok;
    logic             dup;
    logic [EW-1:0]    epoch_inc;
    logic             epoch_wrap;
    logic [31:0]      cur_ext;
    logic [31:0]      load_ext;
    logic [15:0]      mag_full;
    logic [31:0]      mag_ext;
    logic [31:0]      mag_sel;
    logic [EW-1:0]    seen_rd;

    ldabk_pkg::t_node node_wr;
    ldabk_pkg::t_node node_rd;

    assign accept   = i_in.valid && in_ready;
    assign out_free = !r_ovalid || o_out.ready;
    assign clr_last = ({{(32-MW){1'b0}}, r_clr} == 32'(KEY_MAGNITUDES - 1));

    // A cursor counts as a node only when it is non-negative and inside the store.
    assign cur_ext  = {15'd0, r_cursor[ldabk_pkg::ADDR_W-1:0]};
    assign cur_ok   = !r_cursor[ldabk_pkg::LINK_W-1] && (cur_ext < 32'(NODE_SLOTS));
    assign load_ext = {15'd0, i_in.node_addr};
    assign load_ok  = load_ext < 32'(NODE_SLOTS);

    assign epoch_inc  = r_epoch + EW'(1);
    assign epoch_wrap = (epoch_inc == '0);

    // Absolute key; the most negative key folds onto the last map entry.
    assign mag_full = node_rd.key[ldabk_pkg::KEY_W-1]
                    ? ({2'b00, ~node_rd.key[ldabk_pkg::KEY_W-2:0]} + 16'd1)
                    : {1'b0, node_rd.key};
    assign mag_ext  = {16'd0, mag_full};
    assign mag_sel  = (mag_ext >= 32'(KEY_MAGNITUDES)) ? 32'(KEY_MAGNITUDES - 1) : mag_ext;

    assign dup = (seen_rd == r_epoch);

    assign node_wr.key  = i_in.node_key;
    assign node_wr.link = i_in.link_addr;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ldabk_pkg::ST_CLEAR: begin
                if (clr_last) begin
                    n_state = ldabk_pkg::ST_IDLE;
                end
            end
            ldabk_pkg::ST_IDLE: begin
                if (accept) begin
                    if (i_in.kind == ldabk_pkg::KIND_START) begin
                        n_state = epoch_wrap ? ldabk_pkg::ST_CLEAR : ldabk_pkg::ST_IDLE;
                    end else if (i_in.kind == ldabk_pkg::KIND_ADV) begin
                        n_state = cur_ok ? ldabk_pkg::ST_NODE_RD : ldabk_pkg::ST_EMIT;
                    end
                end
            end
            ldabk_pkg::ST_NODE_RD: begin
                n_state = ldabk_pkg::ST_EMIT;
            end
            ldabk_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_state = ldabk_pkg::ST_IDLE;
                end
            end
            default: n_state = ldabk_pkg::ST_CLEAR;
        endcase
    end

    always_comb begin
        in_ready = 1'b0;
        node_we  = 1'b0;
        node_re  = 1'b0;
        seen_re  = 1'b0;
        seen_we  = 1'b0;
        seen_wa  = r_mag;
        seen_wd  = r_epoch;
        out_load = 1'b0;
        unique case (r_state)
            ldabk_pkg::ST_CLEAR: begin
                seen_we = 1'b1;
                seen_wa = r_clr;
                seen_wd = '0;
            end
            ldabk_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                node_we  = accept && (i_in.kind == ldabk_pkg::KIND_LOAD) && load_ok;
                node_re  = accept && (i_in.kind == ldabk_pkg::KIND_ADV) && cur_ok;
            end
            ldabk_pkg::ST_NODE_RD: begin
                seen_re = 1'b1;
            end
            ldabk_pkg::ST_EMIT: begin
                out_load = out_free;
                seen_we  = out_free && !r_null && !dup;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ldabk_pkg::ST_CLEAR;
            r_cursor <= '1;
            r_epoch  <= EW'(1);
            r_clr    <= '0;
            r_null   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (r_state == ldabk_pkg::ST_CLEAR) begin
                r_clr <= clr_last ? '0 : r_clr + MW'(1);
            end

            if (accept && (i_in.kind == ldabk_pkg::KIND_START)) begin
                r_cursor <= i_in.head_addr;
                r_epoch  <= epoch_wrap ? EW'(1) : epoch_inc;
            end else if (accept && (i_in.kind == ldabk_pkg::KIND_ADV)) begin
                r_null <= !cur_ok;
                if (!cur_ok) begin
                    r_cursor <= '1;
                end
            end else if (r_state == ldabk_pkg::ST_NODE_RD) begin
                r_cursor <= node_rd.link;
            end

            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && (i_in.kind == ldabk_pkg::KIND_ADV)) begin
            r_addr <= r_cursor[ldabk_pkg::ADDR_W-1:0];
        end
        if (r_state == ldabk_pkg::ST_NODE_RD) begin
            r_mag <= mag_sel[MW-1:0];
        end
        if (out_load) begin
            r_out_addr    <= r_null ? '0 : r_addr;
            r_out_key     <= r_null ? '0 : node_rd.key;
            r_out_removed <= !r_null && dup;
            r_out_done    <= r_null;
        end
    end

    ldabk_node_mem #(
        .NODE_SLOTS (NODE_SLOTS)
    ) u_node_mem (
        .i_clk     (i_clk),
        .i_wr_en   (node_we),
        .i_wr_addr (load_ext[AW-1:0]),
        .i_wr_data (node_wr),
        .i_rd_en   (node_re),
        .i_rd_addr (cur_ext[AW-1:0]),
        .o_rd_data (node_rd)
    );

    // The seen-map write of one advance lands before the next advance
    // can issue its map read, so no forwarding is needed.
    ldabk_seen_mem #(
        .KEY_MAGNITUDES (KEY_MAGNITUDES)
    ) u_seen_mem (
        .i_clk     (i_clk),
        .i_wr_en   (seen_we),
        .i_wr_addr (seen_wa),
        .i_wr_data (seen_wd),
        .i_rd_en   (seen_re),
        .i_rd_addr (mag_sel[MW-1:0]),
        .o_rd_data (seen_rd)
    );

    assign i_in.ready      = in_ready;
    assign o_out.valid     = r_ovalid;
    assign o_out.out_addr  = r_out_addr;
    assign o_out.out_key   = r_out_key;
    assign o_out.removed   = r_out_removed;
    assign o_out.walk_done = r_out_done;

endmodule

### hw/rtl/ldabk_chk.sv
// Port-level checker for the list deduplication block, bound to its top level.
// Depends on ldabk_pkg for the kind codes.
module ldabk_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                i_in_ready,
    input logic [1:0]                          i_in_kind,
    input logic                                i_out_valid,
    input logic                                i_out_ready,
    input logic [ldabk_pkg::ADDR_W-1:0]        i_out_addr,
    input logic signed [ldabk_pkg::KEY_W-1:0]  i_out_key,
    input logic                                i_out_removed,
    input logic                                i_out_done
);

    // A waiting result item stays and keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_addr) && $stable(i_out_key)
            && $stable(i_out_removed) && $stable(i_out_done))
        else $error("result item changed while stalled");

    // An end-of-list item carries no node.
    a_done_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_done |-> i_out_addr == '0 && i_out_key == '0 && !i_out_removed)
        else $error("end-of-list item carries node fields");

    // An advance occupies the block: no further item is taken straight after it.
    a_adv_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_kind == ldabk_pkg::KIND_ADV |=> !i_in_ready)
        else $error("item taken during an advance");

    // A load or an unused kind finishes at once.
    a_load_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_kind != ldabk_pkg::KIND_START
        && i_in_kind != ldabk_pkg::KIND_ADV |=> i_in_ready)
        else $error("block stalled after a load item");

    // A new result only appears from the busy end of an advance.
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result item appeared while the block was idle");

endmodule

bind list_dedup_by_abs_key ldabk_chk u_ldabk_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_in_kind     (i_in.kind),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_addr    (o_out.out_addr),
    .i_out_key     (o_out.out_key),
    .i_out_removed (o_out.removed),
    .i_out_done    (o_out.walk_done)
);
